// ----- rtl/core/tfn_pkg.sv -----
// Types and constants shared by the triangle face normal pipeline.
// No dependencies; every other file of the block imports this package.
package tfn_pkg;

  localparam int CW  = 16;           // vertex coordinate width
  localparam int EW  = 17;           // edge vector component width
  localparam int PW  = 34;           // edge product width
  localparam int MW  = 34;           // cross product magnitude width
  localparam int HW  = 17;           // half of a magnitude for the square split
  localparam int SQW = 68;           // width of a square and of the sum of squares
  localparam int FB  = 16;           // fraction bits of the length
  localparam int NW  = 100;          // square root operand width (sum << 2*FB)
  localparam int RW  = 50;           // square root result width
  localparam int SW  = 15;           // normal scale width
  localparam int QW  = 15;           // quotient width, never above the scale
  localparam int DW  = 65;           // dividend width (|k| * scale << FB)
  localparam int OW  = 16;           // result component width

  localparam logic [SW-1:0] SCALE_RESET = 15'd16384;

  typedef logic [2:0][CW-1:0] vec_t;

  // Data that rides along with each triangle through the long stages.
  typedef struct packed {
    logic                 last;
    logic                 degen;
    logic [2:0]           neg;
    logic [2:0][MW-1:0]   mag;
  } side_t;

endpackage

// ----- rtl/core/tfn_cross.sv -----
// Edge vectors, edge products and cross product magnitudes (three stages).
// Depends on tfn_pkg.
module tfn_cross (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  tfn_pkg::vec_t in_a,
  input  tfn_pkg::vec_t in_b,
  input  tfn_pkg::vec_t in_c,
  input  logic          in_last,
  output logic          out_valid,
  output tfn_pkg::side_t out_side
);
  import tfn_pkg::*;

  logic signed [EW-1:0] u_r [3];
  logic signed [EW-1:0] v_r [3];
  logic                 last1_r, last2_r;
  logic signed [PW-1:0] p_r [6];
  logic                 vld1_r, vld2_r, vld3_r;
  side_t                side_r;
  side_t                side_nxt;
  logic [PW:0]          k [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k[i] = {p_r[2*i][PW-1], p_r[2*i]} - {p_r[2*i+1][PW-1], p_r[2*i+1]};
      side_nxt.neg[i] = k[i][PW];
      side_nxt.mag[i] = k[i][PW] ? MW'(-k[i]) : k[i][MW-1:0];
    end
    side_nxt.degen = (k[0] == '0) && (k[1] == '0) && (k[2] == '0);
    side_nxt.last  = last2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= {in_b[i][CW-1], in_b[i]} - {in_a[i][CW-1], in_a[i]};
        v_r[i] <= {in_c[i][CW-1], in_c[i]} - {in_a[i][CW-1], in_a[i]};
      end
      last1_r <= in_last;
      p_r[0]  <= u_r[1] * v_r[2];
      p_r[1]  <= u_r[2] * v_r[1];
      p_r[2]  <= u_r[2] * v_r[0];
      p_r[3]  <= u_r[0] * v_r[2];
      p_r[4]  <= u_r[0] * v_r[1];
      p_r[5]  <= u_r[1] * v_r[0];
      last2_r <= last1_r;
      side_r  <= side_nxt;
    end
  end

  assign out_valid = vld3_r;
  assign out_side  = side_r;

endmodule

// ----- rtl/core/tfn_sqsum.sv -----
// Squared length of the cross product from split 17x17 partial products.
// Depends on tfn_pkg.
module tfn_sqsum (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  tfn_pkg::side_t in_side,
  output logic           out_valid,
  output tfn_pkg::side_t out_side,
  output logic [tfn_pkg::SQW-1:0] out_sum
);
  import tfn_pkg::*;

  logic [2*HW-1:0] hh_r [3];
  logic [2*HW-1:0] hl_r [3];
  logic [2*HW-1:0] ll_r [3];
  logic [SQW-1:0]  sq_r [3];
  logic [SQW-1:0]  sum_r;
  side_t           side1_r, side2_r, side3_r;
  logic            vld1_r, vld2_r, vld3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // m^2 = hi^2 * 2^34 + 2 * hi * lo * 2^17 + lo^2
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= in_side.mag[i][MW-1:HW] * in_side.mag[i][MW-1:HW];
        hl_r[i] <= in_side.mag[i][MW-1:HW] * in_side.mag[i][HW-1:0];
        ll_r[i] <= in_side.mag[i][HW-1:0] * in_side.mag[i][HW-1:0];
        sq_r[i] <= {hh_r[i], {2*HW{1'b0}}} + (SQW'(hl_r[i]) << (HW + 1)) + SQW'(ll_r[i]);
      end
      sum_r   <= sq_r[0] + sq_r[1] + sq_r[2];
      side1_r <= in_side;
      side2_r <= side1_r;
      side3_r <= side2_r;
    end
  end

  assign out_valid = vld3_r;
  assign out_side  = side3_r;
  assign out_sum   = sum_r;

endmodule

// ----- rtl/core/tfn_sqrt.sv -----
// Pipelined floor square root, one result bit per stage, of sum << 32.
// Depends on tfn_pkg.
module tfn_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  tfn_pkg::side_t in_side,
  input  logic [tfn_pkg::SQW-1:0] in_sum,
  output logic           out_valid,
  output tfn_pkg::side_t out_side,
  output logic [tfn_pkg::RW-1:0] out_root
);
  import tfn_pkg::*;

  // Entry 0 is the stage input; entry j+1 is the register of stage j.
  logic          vld_r  [RW+1];
  side_t         side_r [RW+1];
  logic [RW-1:0] root_r [RW+1];
  logic [NW:0]   rem_r  [RW];

  assign vld_r[0]  = in_valid;
  assign side_r[0] = in_side;
  assign root_r[0] = '0;
  assign rem_r[0]  = {1'b0, in_sum, {2*FB{1'b0}}};

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int B = RW - 1 - j;
    logic [NW:0] trial;
    logic        fit;

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B); r has no bits at or below B.
    always_comb begin
      trial = ((NW+1)'(root_r[j]) << (B + 1)) | ((NW+1)'(1) << (2 * B));
      fit   = rem_r[j] >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[j+1] <= side_r[j];
        root_r[j+1] <= fit ? (root_r[j] | (RW'(1) << B)) : root_r[j];
      end
    end

    if (j < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1] <= fit ? rem_r[j] - trial : rem_r[j];
        end
      end
    end
  end

  assign out_valid = vld_r[RW];
  assign out_side  = side_r[RW];
  assign out_root  = root_r[RW];

endmodule

// ----- rtl/core/tfn_div.sv -----
// Scaling multiply and restoring division, one quotient bit per stage,
// for all three components in parallel. Depends on tfn_pkg.
module tfn_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [tfn_pkg::SW-1:0] scale,
  input  logic           in_valid,
  input  tfn_pkg::side_t in_side,
  input  logic [tfn_pkg::RW-1:0] in_len,
  output logic           out_valid,
  output tfn_pkg::side_t out_side,
  output logic [2:0][tfn_pkg::QW-1:0] out_quo
);
  import tfn_pkg::*;

  // Entry 0 holds the scaled dividends; entry j+1 is the register of step j.
  logic                 vld_r  [QW+1];
  side_t                side_r [QW+1];
  logic [RW-1:0]        len_r  [QW+1];
  logic [2:0][QW-1:0]   quo_r  [QW+1];
  logic [2:0][DW-1:0]   rem_r  [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= {(MW+SW)'(in_side.mag[i]) * (MW+SW)'(scale), {FB{1'b0}}};
      end
      side_r[0] <= in_side;
      len_r[0]  <= in_len;
      quo_r[0]  <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int B = QW - 1 - j;
    logic [DW-1:0] dvs;
    logic [2:0]    fit;

    always_comb begin
      dvs = DW'(len_r[j]) << B;
      for (int i = 0; i < 3; i++) begin
        fit[i] = rem_r[j][i] >= dvs;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[j+1] <= side_r[j];
        len_r[j+1]  <= len_r[j];
        for (int i = 0; i < 3; i++) begin
          quo_r[j+1][i] <= quo_r[j][i] | (fit[i] ? (QW'(1) << B) : '0);
        end
      end
    end

    if (j < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          for (int i = 0; i < 3; i++) begin
            rem_r[j+1][i] <= fit[i] ? rem_r[j][i] - dvs : rem_r[j][i];
          end
        end
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign out_side  = side_r[QW];
  assign out_quo   = quo_r[QW];

endmodule

// ----- rtl/core/triangle_face_normal.sv -----
// Top level of the triangle face normal pipeline and its output register.
// Depends on tfn_pkg, tfn_cross, tfn_sqsum, tfn_sqrt and tfn_div.
//
// Usage: one triangle (vertices A, B, C as signed 16-bit coordinates) enters
// per transaction on the in_ channel; one scaled unit normal leaves per
// transaction on the out_ channel, in the same order. in_tlast is copied to
// out_tlast; out_tuser is the degenerate flag, set when the cross product is
// zero, in which case the normal is zero.
// The scale is written through cfg_wr_en / cfg_wr_data; the user must do this
// only while the block is idle, which it does not enforce. It resets to 16384.
// From input transaction to output valid, a triangle passes the cross product
// and squared length stages, 50 square root stages (one root bit each), the
// scaling multiply, 15 division stages (one quotient bit each) and the output
// register. Throughput is one triangle per cycle.
// When the receiver holds out_tready low with a result waiting, the whole
// pipeline freezes and in_tready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and restores the scale.
module triangle_face_normal (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
  input  logic [143:0] in_tdata,
  input  logic         in_tlast,   // last_face
  output logic         out_tvalid,
  input  logic         out_tready,
  // normal_x, normal_y, normal_z from bit 0 up
  output logic [47:0]  out_tdata,
  output logic         out_tuser,  // degenerate
  output logic         out_tlast,  // last_result
  input  logic         cfg_wr_en,
  input  logic [14:0]  cfg_wr_data // normal_scale
);
  import tfn_pkg::*;

  logic [SW-1:0]       scale_val_r;
  logic                en;
  vec_t                va, vb, vc;
  logic                x_valid, q_valid, r_valid, d_valid;
  side_t               x_side, q_side, r_side, d_side;
  logic [SQW-1:0]      q_sum;
  logic [RW-1:0]       r_root;
  logic [2:0][QW-1:0]  d_quo;
  logic                out_valid_r;
  logic [47:0]         out_data_r, out_data_nxt;
  logic                out_degen_r, out_last_r;
  logic [OW-1:0]       qm [3];
  logic                bound_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_val_r <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_val_r <= cfg_wr_data;
    end
  end

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = in_tdata[CW*i +: CW];
      vb[i] = in_tdata[CW*(i+3) +: CW];
      vc[i] = in_tdata[CW*(i+6) +: CW];
    end
  end

  tfn_cross u_cross (
    .clk, .rst_n, .en,
    .in_valid (in_tvalid & in_tready),
    .in_a     (va),
    .in_b     (vb),
    .in_c     (vc),
    .in_last  (in_tlast),
    .out_valid(x_valid),
    .out_side (x_side)
  );

  tfn_sqsum u_sqsum (
    .clk, .rst_n, .en,
    .in_valid (x_valid),
    .in_side  (x_side),
    .out_valid(q_valid),
    .out_side (q_side),
    .out_sum  (q_sum)
  );

  tfn_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (q_valid),
    .in_side  (q_side),
    .in_sum   (q_sum),
    .out_valid(r_valid),
    .out_side (r_side),
    .out_root (r_root)
  );

  tfn_div u_div (
    .clk, .rst_n, .en,
    .scale    (scale_val_r),
    .in_valid (r_valid),
    .in_side  (r_side),
    .in_len   (r_root),
    .out_valid(d_valid),
    .out_side (d_side),
    .out_quo  (d_quo)
  );

  // A zero length makes every quotient bit fit, so degenerate forces zero.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qm[i] = {1'b0, d_quo[i]};
      if (d_side.degen) begin
        out_data_nxt[OW*i +: OW] = '0;
      end else if (d_side.neg[i]) begin
        out_data_nxt[OW*i +: OW] = -qm[i];
      end else begin
        out_data_nxt[OW*i +: OW] = qm[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r  <= out_data_nxt;
      out_degen_r <= d_side.degen;
      out_last_r  <= d_side.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_degen_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    bound_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (($signed(out_data_r[OW*i +: OW]) > $signed({1'b0, scale_val_r})) ||
          ($signed(out_data_r[OW*i +: OW]) < -$signed({1'b0, scale_val_r}))) begin
        bound_ok = 1'b0;
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result with nonzero normal");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> bound_ok)
    else $error("normal component exceeds the scale");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(d_valid) && $stable(d_quo))
    else $error("pipeline moved while the output was stalled");

endmodule

// ----- test/triangle_face_normal_tb.sv -----
// Testbench for triangle_face_normal: drives triangles with random gaps and
// checks each scaled unit normal against a predictor built on wide integers.
// Depends on the RTL of triangle_face_normal only.
`timescale 1ns / 100ps

module triangle_face_normal_tb;

  localparam int LATENCY = 73;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        degen;
    logic        last;
  } normal_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_wr_en;
  logic [14:0]  cfg_wr_data;

  logic [14:0]  scale;
  normal_t      expected_normals[$];
  int           errors = 0;
  longint       cycles = 0;

  triangle_face_normal dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("triangle_face_normal test failed");
      $finish;
    end
  end

  // Floor square root of a value below 2^100, one result bit per pass.
  function automatic logic [49:0] root_floor(logic [99:0] n);
    logic [49:0] r;
    logic [49:0] t;
    r = '0;
    for (int b = 49; b >= 0; b--) begin
      t = r | (50'd1 << b);
      if ({100'd0, t} * {100'd0, t} <= {100'd0, n}) r = t;
    end
    return r;
  endfunction

  function automatic logic [15:0] scaled_part(logic signed [35:0] k, logic [49:0] len,
                                              logic [14:0] s);
    logic [35:0] m;
    logic [79:0] q;
    m = k < 0 ? -k : k;
    q = ({44'd0, m} * s << 16) / len;
    if (k < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic normal_t face_normal(logic [143:0] v, logic last);
    logic signed [35:0] c[9];
    logic signed [35:0] ux, uy, uz, vx, vy, vz, kx, ky, kz;
    logic [99:0] sum;
    logic [49:0] len;
    normal_t r;
    for (int i = 0; i < 9; i++) c[i] = $signed(v[i*16 +: 16]);
    ux = c[3] - c[0]; uy = c[4] - c[1]; uz = c[5] - c[2];
    vx = c[6] - c[0]; vy = c[7] - c[1]; vz = c[8] - c[2];
    kx = uy * vz - uz * vy;
    ky = uz * vx - ux * vz;
    kz = ux * vy - uy * vx;
    sum = 100'(kx) * 100'(kx) + 100'(ky) * 100'(ky) + 100'(kz) * 100'(kz);
    r.last = last;
    if (sum == 0) begin
      r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
    end else begin
      len = root_floor(sum << 32);
      r.nx = scaled_part(kx, len, scale);
      r.ny = scaled_part(ky, len, scale);
      r.nz = scaled_part(kz, len, scale);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // Result checker with random receiver stalls.
  initial begin
    normal_t want;
    int stall;
    out_tready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (expected_normals.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[15:0], 16'd0);
        end else begin
          want = expected_normals.pop_front();
          if (out_tdata[15:0] !== want.nx) report_mismatch("normal_x", out_tdata[15:0], want.nx);
          if (out_tdata[31:16] !== want.ny) report_mismatch("normal_y", out_tdata[31:16], want.ny);
          if (out_tdata[47:32] !== want.nz) report_mismatch("normal_z", out_tdata[47:32], want.nz);
          if (out_tuser !== want.degen) report_mismatch("degenerate", out_tuser, want.degen);
          if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
        end
        stall = ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_triangle(logic [143:0] v, logic last, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    expected_normals.push_back(face_normal(v, last));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_scale(logic [14:0] s);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scale = s;
  endtask

  function automatic logic [143:0] pack_tri(int ax, int ay, int az, int bx, int by, int bz,
                                            int cx, int cy, int cz);
    return {16'(cz), 16'(cy), 16'(cx), 16'(bz), 16'(by), 16'(bx), 16'(az), 16'(ay), 16'(ax)};
  endfunction

  task automatic test_directed();
    send_triangle(pack_tri(0, 0, 0, 1, 0, 0, 0, 1, 0), 0);
    send_triangle(pack_tri(0, 0, 0, 0, 1, 0, 1, 0, 0), 0);
    send_triangle(pack_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
    send_triangle(pack_tri(1, 2, 3, 2, 4, 6, 3, 6, 9), 0);
    send_triangle(pack_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                           -32768, 32767, -32768), 0);
    send_triangle(pack_tri(32767, 32767, 32767, -32768, 32767, -32768,
                           -32768, -32768, 32767), 1);
    send_triangle(pack_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                           32767, 32767, -32768), 0);
    send_triangle(pack_tri(5, 5, 5, 5, 5, 5, 9, -3, 7), 0);
    send_triangle({144{1'b1}}, 1);
    send_triangle(pack_tri(0, 0, 0, 3, 4, 0, -7, 1, 2), 0);
  endtask

  task automatic test_random(int count);
    logic [143:0] v;
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 9; j++) begin
        case ($urandom_range(3))
          0: v[j*16 +: 16] = 16'($signed($urandom_range(16)) - 8);
          1: v[j*16 +: 16] = $urandom_range(1) ? 16'h7fff : 16'h8000;
          default: v[j*16 +: 16] = 16'($urandom);
        endcase
      end
      // Some collinear triangles to hit the zero cross product.
      if ($urandom_range(15) == 0) v[143:96] = v[95:48];
      send_triangle(v, 1'($urandom), $urandom_range(3) == 0);
    end
  endtask

  initial begin
    scale = 15'd16384;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(200);
    drain();
    write_scale(15'd32767);
    test_directed();
    test_random(250);
    drain();
    write_scale(15'd0);
    test_directed();
    test_random(100);
    drain();
    write_scale(15'd1);
    test_random(150);
    drain();
    write_scale(15'($urandom));
    test_random(250);
    drain();

    if (errors == 0) begin
      $display("triangle_face_normal test passed");
    end else begin
      $display("triangle_face_normal test failed");
    end
    $finish;
  end

endmodule
